// File: design/tcgr_pkg.sv
package tcgr_pkg;

	localparam int unsigned MaxGlyphs     = 256;
	localparam int unsigned MaxGlyphLines = 32;
	localparam int unsigned GlyphIdxW     = $clog2(MaxGlyphs);
	localparam int unsigned LineIdxW      = $clog2(MaxGlyphLines);
	localparam int unsigned StoreAddrW    = GlyphIdxW + LineIdxW;
	localparam int unsigned StoreDepth    = MaxGlyphs * MaxGlyphLines;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic CMD_PRINT = 1'b0;
	localparam logic CMD_LOAD  = 1'b1;

	localparam logic [2:0] REG_FRAME_BASE   = 3'd0;
	localparam logic [2:0] REG_LINE_PITCH   = 3'd1;
	localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd2;
	localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd3;
	localparam logic [2:0] REG_GLYPH_COUNT  = 3'd4;
	localparam logic [2:0] REG_TEXT_ROWS    = 3'd5;
	localparam logic [2:0] REG_TEXT_COLUMNS = 3'd6;

	localparam logic [29:0] RST_FRAME_BASE   = 30'd0;
	localparam logic [15:0] RST_LINE_PITCH   = 16'd4096;
	localparam logic [5:0]  RST_GLYPH_HEIGHT = 6'd16;
	localparam logic [3:0]  RST_GLYPH_WIDTH  = 4'd8;
	localparam logic [8:0]  RST_GLYPH_COUNT  = 9'd256;
	localparam logic [7:0]  RST_TEXT_ROWS    = 8'd48;
	localparam logic [7:0]  RST_TEXT_COLUMNS = 8'd128;

	typedef struct packed {
		logic       command;
		logic [7:0] char_code;
		logic [4:0] glyph_line;
		logic [7:0] glyph_bits;
	} item_t;

	typedef struct packed {
		logic [31:0] row_address;
		logic [7:0]  pixel_bits;
		logic        last_line;
	} pix_t;

	function automatic logic [7:0] keep_mask(input logic [3:0] w);
		return ~(8'hff >> w);
	endfunction

endpackage

// File: design/text_console_glyph_renderer.sv
// text console glyph renderer
//
// item channel (item_valid / item_stall / item): one transaction per command.
// a load command writes one glyph line into the internal font store; a print
// command draws one character at the cursor, or moves it for CR and LF; BS steps back and draws a space.
// pix channel (pix_valid / pix_stall / pix): one transaction per glyph line,
// carrying the framebuffer byte address, the 8-bit pattern and a last mark.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
// always ready; write only while the block is idle.
// load, CR, LF and a print with zero glyph height finish in S_IDLE. for a drawn
// character, the shared multiply-add unit builds the cell address in S_MROW,
// S_MPITCH and S_MCOL, then in S_DRAW one glyph line per cycle, unless pix
// stalls, is read from the font store and stepped by the line pitch in that unit.
// each line is registered in the font store read register, then in the pix output register.
// item_stall stays high while a character is drawn. a stall on pix holds the
// output register and the line sequencer waits behind it.
// reset clears cursor and all valids and sets the registers to their defaults; the font store is not
// cleared and must be loaded before use.
module text_console_glyph_renderer
	import tcgr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        pix_valid,
	input  logic        pix_stall,
	output pix_t        pix,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_MROW   = 5'b00010,
		S_MPITCH = 5'b00100,
		S_MCOL   = 5'b01000,
		S_DRAW   = 5'b10000
	} state_t;

	state_t state_q;

	logic [29:0] frame_base_q;
	logic [15:0] line_pitch_q;
	logic [5:0]  glyph_height_q;
	logic [3:0]  glyph_width_q;
	logic [8:0]  glyph_count_q;
	logic [7:0]  text_rows_q;
	logic [7:0]  text_columns_q;

	logic [7:0]  col_q;
	logic [7:0]  row_q;
	logic [7:0]  draw_col_q;
	logic [GlyphIdxW-1:0] glyph_q;
	logic [5:0]  h_q;
	logic [5:0]  j_q;
	logic [7:0]  keep_q;
	logic [31:0] acc_q;

	logic [7:0]  glyph_mem_q [StoreDepth];
	logic [7:0]  rd_s1;
	logic [31:0] addr_s1;
	logic        last_s1;
	logic        pend_q;

	logic        pix_valid_q;
	pix_t        pix_q;

	logic        accept;
	logic        is_load;
	logic        is_crlf;
	logic        is_bs;
	logic [7:0]  last_col;
	logic [7:0]  last_row;
	logic [7:0]  back_col;
	logic [7:0]  code_sel;
	logic        code_ok;
	logic [3:0]  w_c;
	logic [3:0]  w_p1;
	logic [5:0]  h_c;

	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [31:0] add_c;
	logic [31:0] prod;
	logic [31:0] unit_res;

	logic        load_now;
	logic        issue;
	logic        draw_done;

	assign accept  = item_valid && !item_stall;
	assign is_load = item.command == CMD_LOAD;
	assign is_crlf = !is_load && (item.char_code == CH_CR || item.char_code == CH_LF);
	assign is_bs   = !is_load && item.char_code == CH_BS;

	assign last_col = (text_columns_q == 8'd0) ? 8'd0 : text_columns_q - 8'd1;
	assign last_row = (text_rows_q == 8'd0) ? 8'd0 : text_rows_q - 8'd1;
	assign back_col = (col_q == 8'd0) ? 8'd0 : col_q - 8'd1;
	assign code_sel = is_bs ? CH_SPACE : item.char_code;
	assign code_ok  = glyph_count_q[8] || (code_sel < glyph_count_q[7:0]);
	assign w_c      = (glyph_width_q > 4'd8) ? 4'd8 : glyph_width_q;
	assign w_p1     = w_c + 4'd1;
	assign h_c      = (glyph_height_q > 6'(MaxGlyphLines)) ? 6'(MaxGlyphLines)
	                                                        : glyph_height_q;

	// shared multiply-add unit
	always_comb begin
		mul_a = 16'd0;
		mul_b = 16'd0;
		add_c = 32'd0;
		case (state_q)
			S_MROW: begin
				mul_a = {8'd0, row_q};
				mul_b = {10'd0, glyph_height_q};
			end
			S_MPITCH: begin
				mul_a = acc_q[15:0];
				mul_b = line_pitch_q;
				add_c = {2'd0, frame_base_q};
			end
			S_MCOL: begin
				mul_a = {8'd0, draw_col_q};
				mul_b = {10'd0, w_p1, 2'b00};
				add_c = acc_q;
			end
			S_DRAW: begin
				mul_a = line_pitch_q;
				mul_b = 16'd1;
				add_c = acc_q;
			end
			default: begin
				mul_a = 16'd0;
			end
		endcase
	end

	assign prod     = {16'd0, mul_a} * {16'd0, mul_b};
	assign unit_res = prod + add_c;

	assign load_now  = pend_q && (!pix_valid_q || !pix_stall);
	assign issue     = (state_q == S_DRAW) && (j_q != h_q) && (!pend_q || load_now);
	assign draw_done = (state_q == S_DRAW) && (j_q == h_q) && (!pend_q || load_now);

	assign item_stall = state_q != S_IDLE;
	assign cfg_ready  = 1'b1;
	assign pix_valid  = pix_valid_q;
	assign pix        = pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q   <= RST_FRAME_BASE;
			line_pitch_q   <= RST_LINE_PITCH;
			glyph_height_q <= RST_GLYPH_HEIGHT;
			glyph_width_q  <= RST_GLYPH_WIDTH;
			glyph_count_q  <= RST_GLYPH_COUNT;
			text_rows_q    <= RST_TEXT_ROWS;
			text_columns_q <= RST_TEXT_COLUMNS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_BASE:   frame_base_q   <= cfg_data[29:0];
				REG_LINE_PITCH:   line_pitch_q   <= cfg_data[15:0];
				REG_GLYPH_HEIGHT: glyph_height_q <= cfg_data[5:0];
				REG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data[3:0];
				REG_GLYPH_COUNT:  glyph_count_q  <= cfg_data[8:0];
				REG_TEXT_ROWS:    text_rows_q    <= cfg_data[7:0];
				REG_TEXT_COLUMNS: text_columns_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= 8'd0;
			row_q   <= 8'd0;
			pend_q  <= 1'b0;
			j_q     <= 6'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && !is_load) begin
						if (is_crlf) begin
							col_q <= 8'd0;
							if (row_q < last_row) begin
								row_q <= row_q + 8'd1;
							end
						end else begin
							if (is_bs) begin
								col_q <= back_col;
							end else if (col_q < last_col) begin
								col_q <= col_q + 8'd1;
							end
							j_q <= 6'd0;
							if (h_c != 6'd0) begin
								state_q <= S_MROW;
							end
						end
					end
				end
				S_MROW:   state_q <= S_MPITCH;
				S_MPITCH: state_q <= S_MCOL;
				S_MCOL:   state_q <= S_DRAW;
				S_DRAW: begin
					if (issue) begin
						j_q <= j_q + 6'd1;
					end
					if (draw_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (issue) begin
				pend_q <= 1'b1;
			end else if (load_now) begin
				pend_q <= 1'b0;
			end
		end
	end

	// per-item draw setup and address accumulator
	always_ff @(posedge clk) begin
		if (accept && !is_load && !is_crlf) begin
			draw_col_q <= is_bs ? back_col : col_q;
			glyph_q    <= code_ok ? code_sel : '0;
			h_q        <= h_c;
			keep_q     <= keep_mask(w_c);
		end
		if (state_q == S_MROW || state_q == S_MPITCH || state_q == S_MCOL || issue) begin
			acc_q <= unit_res;
		end
		if (issue) begin
			addr_s1 <= acc_q;
			last_s1 <= 6'(j_q + 6'd1) == h_q;
		end
	end

	// font store
	always_ff @(posedge clk) begin
		if (accept && is_load) begin
			glyph_mem_q[{item.char_code, item.glyph_line}] <= item.glyph_bits;
		end
		if (issue) begin
			rd_s1 <= glyph_mem_q[{glyph_q, j_q[LineIdxW-1:0]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (load_now) begin
			pix_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_now) begin
			pix_q.row_address <= addr_s1;
			pix_q.pixel_bits  <= rd_s1 & keep_q;
			pix_q.last_line   <= last_s1;
		end
	end

endmodule

// File: design/tcgr_checker.sv
module tcgr_checker
	import tcgr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  item_t       item,
	input  logic        pix_valid,
	input  logic        pix_stall,
	input  pix_t        pix,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic item_take;
	logic unused_cfg;

	assign item_take  = item_valid && !item_stall;
	assign unused_cfg = cfg_valid && cfg_ready && (cfg_index == REG_FRAME_BASE) && cfg_data[0];

	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid)
		else $error("pix transaction dropped while stalled");

	a_pix_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> $stable(pix))
		else $error("pix payload changed while stalled");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && item.command == CMD_LOAD |=> !item_stall)
		else $error("load transaction did not complete in one cycle");

	a_crlf_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && item.command == CMD_PRINT &&
		(item.char_code == CH_CR || item.char_code == CH_LF) |=> !item_stall)
		else $error("cursor move did not complete in one cycle");

	a_mid_glyph_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix.last_line |-> item_stall)
		else $error("item channel ready in the middle of a glyph");

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (.*);

// File: dv/glyph_line_checker.sv
`timescale 1ns / 1ps
module glyph_line_checker
	import tcgr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  item_t       item,
	input  logic        pix_valid,
	input  logic        pix_stall,
	input  pix_t        pix,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          lines_checked,
	output int          chars_drawn
);

	logic [29:0] frame_base;
	logic [15:0] line_pitch;
	logic [5:0]  glyph_height;
	logic [3:0]  glyph_width;
	logic [8:0]  glyph_count;
	logic [7:0]  text_rows;
	logic [7:0]  text_columns;

	logic [7:0]  cur_col;
	logic [7:0]  cur_row;
	logic [7:0]  font [StoreDepth];
	pix_t        expected_lines [$];

	task automatic flag(input string msg);
		errors++;
		if (errors <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// queue the glyph lines of one cell at the cursor, then step the column
	function automatic void draw_cell(input logic [7:0] code);
		int unsigned count;
		int unsigned glyph;
		int unsigned h;
		int unsigned w;
		logic [7:0]  keep;
		logic [63:0] base;
		pix_t        p;
		count = (glyph_count > MaxGlyphs) ? MaxGlyphs : glyph_count;
		glyph = (code < count) ? code : 0;
		h = (glyph_height > MaxGlyphLines) ? MaxGlyphLines : glyph_height;
		w = (glyph_width > 8) ? 8 : glyph_width;
		keep = 8'(16'hff00 >> w);
		base = 64'(frame_base) + 64'(cur_row) * 64'(glyph_height) * 64'(line_pitch)
			+ 64'(cur_col) * 64'(w + 1) * 64'd4;
		for (int j = 0; j < h; j++) begin
			p.row_address = 32'(base + 64'(j) * 64'(line_pitch));
			p.pixel_bits = font[StoreAddrW'(glyph * MaxGlyphLines + j)] & keep;
			p.last_line = (j + 1 == h);
			expected_lines.push_back(p);
		end
		chars_drawn++;
		if (int'(cur_col) + 1 < int'(text_columns))
			cur_col++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pix_t       want;
		logic [7:0] back;
		if (!arst_n) begin
			frame_base = RST_FRAME_BASE;
			line_pitch = RST_LINE_PITCH;
			glyph_height = RST_GLYPH_HEIGHT;
			glyph_width = RST_GLYPH_WIDTH;
			glyph_count = RST_GLYPH_COUNT;
			text_rows = RST_TEXT_ROWS;
			text_columns = RST_TEXT_COLUMNS;
			cur_col = '0;
			cur_row = '0;
			expected_lines.delete();
			errors = 0;
			pending = 0;
			lines_checked = 0;
			chars_drawn = 0;
		end else begin
			if (pix_valid && !pix_stall) begin
				lines_checked++;
				if (expected_lines.size() == 0) begin
					flag($sformatf("unexpected line transaction, address %h bits %h last %b",
						pix.row_address, pix.pixel_bits, pix.last_line));
				end else begin
					want = expected_lines.pop_front();
					if (pix.row_address !== want.row_address)
						flag($sformatf("row_address expected %h got %h",
							want.row_address, pix.row_address));
					if (pix.pixel_bits !== want.pixel_bits)
						flag($sformatf("pixel_bits at %h expected %h got %h",
							want.row_address, want.pixel_bits, pix.pixel_bits));
					if (pix.last_line !== want.last_line)
						flag($sformatf("last_line at %h expected %b got %b",
							want.row_address, want.last_line, pix.last_line));
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_BASE:   frame_base = cfg_data[29:0];
					REG_LINE_PITCH:   line_pitch = cfg_data[15:0];
					REG_GLYPH_HEIGHT: glyph_height = cfg_data[5:0];
					REG_GLYPH_WIDTH:  glyph_width = cfg_data[3:0];
					REG_GLYPH_COUNT:  glyph_count = cfg_data[8:0];
					REG_TEXT_ROWS:    text_rows = cfg_data[7:0];
					REG_TEXT_COLUMNS: text_columns = cfg_data[7:0];
					default: ;
				endcase
			end

			if (item_valid && !item_stall) begin
				if (item.command == CMD_LOAD) begin
					font[{item.char_code, item.glyph_line}] = item.glyph_bits;
				end else if (item.char_code == CH_CR || item.char_code == CH_LF) begin
					cur_col = '0;
					if (int'(cur_row) + 1 < int'(text_rows))
						cur_row++;
				end else if (item.char_code == CH_BS) begin
					back = (cur_col != 0) ? cur_col - 8'd1 : 8'd0;
					cur_col = back;
					draw_cell(CH_SPACE);
					cur_col = back;
				end else begin
					draw_cell(item.char_code);
				end
			end

			pending = expected_lines.size();
		end
	end

endmodule

// File: dv/tb_text_console_glyph_renderer.sv
`timescale 1ns / 1ps
module tb_text_console_glyph_renderer;
	import tcgr_pkg::*;

	localparam int unsigned CycleLimit = 800000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        pix_valid;
	logic        pix_stall = 1'b0;
	pix_t        pix;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_FRAME_BASE;
	logic [31:0] cfg_data = '0;

	int errors;
	int pending;
	int lines_checked;
	int chars_drawn;

	int unsigned cycle_count = 0;
	int unsigned idle_odds = 0;
	int unsigned stall_left = 0;
	int unsigned font_height = RST_GLYPH_HEIGHT;
	int unsigned font_count = RST_GLYPH_COUNT;
	bit          font_loaded [StoreDepth];
	int          prints = 0;
	int          loads = 0;
	int          settings = 0;

	text_console_glyph_renderer u_dut (.*);
	glyph_line_checker u_checker (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d lines still expected", cycle_count, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// line back-pressure in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds / 2) begin
			pix_stall <= 1'b1;
			stall_left <= $urandom_range(0, 5);
		end else begin
			pix_stall <= 1'b0;
		end
	end

	function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	task automatic send_item(input item_t it);
		if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic load_line(input logic [7:0] glyph, input logic [4:0] line,
		input logic [7:0] bits);
		item_t it;
		it.command = CMD_LOAD;
		it.char_code = glyph;
		it.glyph_line = line;
		it.glyph_bits = bits;
		send_item(it);
		font_loaded[{glyph, line}] = 1'b1;
		loads++;
	endtask

	// fill any font lines the next print will read
	task automatic prepare_glyph(input logic [7:0] code);
		int unsigned g;
		if (code == CH_CR || code == CH_LF)
			return;
		g = (code == CH_BS) ? CH_SPACE : code;
		if (g >= font_count)
			g = 0;
		for (int j = 0; j < font_height; j++)
			if (!font_loaded[StoreAddrW'(g * MaxGlyphLines + j)])
				load_line(8'(g), 5'(j), 8'($urandom));
	endtask

	task automatic print_char(input logic [7:0] code);
		item_t it;
		prepare_glyph(code);
		it.command = CMD_PRINT;
		it.char_code = code;
		it.glyph_line = 5'($urandom);
		it.glyph_bits = 8'($urandom);
		send_item(it);
		prints++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 32'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic reconfigure(input int unsigned base, input int unsigned pitch,
		input int unsigned height, input int unsigned width, input int unsigned count,
		input int unsigned rows, input int unsigned cols);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(REG_FRAME_BASE, base);
		write_reg(REG_LINE_PITCH, pitch);
		write_reg(REG_GLYPH_HEIGHT, height);
		write_reg(REG_GLYPH_WIDTH, width);
		write_reg(REG_GLYPH_COUNT, count);
		write_reg(REG_TEXT_ROWS, rows);
		write_reg(REG_TEXT_COLUMNS, cols);
		cfg_valid <= 1'b0;
		@(posedge clk);
		font_height = height;
		font_count = count;
		settings++;
	endtask

	task automatic shuffle_settings();
		int unsigned h;
		h = $urandom_range(1, 4);
		reconfigure(pick(0, 30'h3fffffff), pick(1, 65535), h, pick(1, 8), pick(1, 256),
			pick(1, 255), pick(1, 255));
	endtask

	task automatic random_item();
		int unsigned roll;
		logic [7:0]  code;
		roll = $urandom_range(0, 99);
		if (roll < 20) begin
			load_line(8'($urandom), 5'($urandom), 8'($urandom));
		end else begin
			if (roll < 30)
				code = ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
			else if (roll < 38)
				code = CH_BS;
			else if (roll < 50)
				code = 8'($urandom_range(0, font_count - 1));
			else
				code = 8'($urandom);
			print_char(code);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// large addresses with wrap, tall glyphs, tiny screen
		idle_odds = 30;
		reconfigure(30'h3fffffff, 65535, 32, 8, 1, 3, 4);
		load_line(8'hff, 5'd31, 8'hff);
		load_line(8'h00, 5'd0, 8'h00);
		print_char(CH_BS);
		print_char(8'h00);
		print_char(8'd199);
		print_char(8'd200);
		print_char(8'hff);
		print_char(8'h41);
		print_char(CH_BS);
		print_char(CH_CR);
		print_char(CH_LF);
		print_char(CH_LF);
		print_char(8'h7f);

		// frame base zero, every other register at one
		reconfigure(0, 1, 1, 1, 1, 1, 1);
		print_char(8'h41);
		print_char(CH_BS);
		print_char(CH_LF);
		print_char(8'hff);
		load_line(8'h00, 5'd0, 8'h55);
		print_char(8'h00);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_odds = 25;
				1: idle_odds = 0;
				2: idle_odds = 50;
				default: idle_odds = 35;
			endcase
			shuffle_settings();
			repeat (11) random_item();
		end

		idle_odds = 0;
		shuffle_settings();
		repeat (8) random_item();

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d print and %0d font load transactions across %0d register settings",
			prints, loads, settings);
		$display("compared %0d glyph lines from %0d drawn cells, %0d mismatches",
			lines_checked, chars_drawn, errors);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
